>>> rtl/wnpip_pkg.sv
// Shared types and constants of the winding-number point-in-polygon unit.
`default_nettype none

package wnpip_pkg;

    // Fixed field widths of the request and response beats.
    localparam int COORD_BITS = 16;
    localparam int INDEX_BITS = 8;
    localparam int COUNT_BITS = 9;
    localparam int WN_OUT_W   = 9;

    // Output winding-number range; wider internal values saturate to it.
    localparam int WN_OUT_MAX = 255;
    localparam int WN_OUT_MIN = -256;

    // Coordinate differences and their exact products.
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;

    // Request beat kinds.
    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    // One request beat.
    typedef struct packed {
        kind_t                         kind;
        logic [INDEX_BITS-1:0]         vertex_index;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
    } req_t;

    // One response beat.
    typedef struct packed {
        logic signed [WN_OUT_W-1:0] winding_number;
        logic                       inside_res;
    } rsp_t;

    // Query token handed from cell to cell: the point and the pending
    // crossing test of the edge owned by the previous cell.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic                         pend_up;
        logic                         pend_dn;
        logic signed [PROD_W-1:0]     prod_l;
        logic signed [PROD_W-1:0]     prod_r;
    } tok_t;

endpackage

`default_nettype wire

>>> rtl/wnpip_cell.sv
// One cell of the edge chain: holds one vertex and tests the edge it starts.
`default_nettype none

module wnpip_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 9,
    parameter int WN_W  = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   load,
    input  logic [wnpip_pkg::INDEX_BITS-1:0]       ld_idx,
    input  logic signed [wnpip_pkg::COORD_BITS-1:0] ld_x,
    input  logic signed [wnpip_pkg::COORD_BITS-1:0] ld_y,
    input  logic signed [wnpip_pkg::COORD_BITS-1:0] nx,
    input  logic signed [wnpip_pkg::COORD_BITS-1:0] ny,
    input  logic signed [wnpip_pkg::COORD_BITS-1:0] v0x,
    input  logic signed [wnpip_pkg::COORD_BITS-1:0] v0y,
    input  logic [CNT_W-1:0]                       n_cnt,
    input  logic [CNT_W-1:0]                       n_last,
    input  logic                                   vld_in,
    input  wnpip_pkg::tok_t                        tok_in,
    input  logic signed [WN_W-1:0]                 wn_in,
    output logic signed [wnpip_pkg::COORD_BITS-1:0] vx,
    output logic signed [wnpip_pkg::COORD_BITS-1:0] vy,
    output logic                                   vld_out,
    output wnpip_pkg::tok_t                        tok_out,
    output logic signed [WN_W-1:0]                 wn_out
);
    import wnpip_pkg::*;

    logic signed [COORD_BITS-1:0] vx_reg;
    logic signed [COORD_BITS-1:0] vy_reg;
    logic                         vld_reg;
    tok_t                         tok_reg;
    tok_t                         tok_next;
    logic signed [WN_W-1:0]       wn_reg;
    logic signed [WN_W-1:0]       wn_next;

    logic                         active;
    logic                         is_last;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    logic signed [DIFF_W-1:0]     dx_e;
    logic signed [DIFF_W-1:0]     dy_e;
    logic signed [DIFF_W-1:0]     dx_p;
    logic signed [DIFF_W-1:0]     dy_p;
    logic                         hit_up;
    logic                         hit_dn;

    // This cell owns an edge when its index is below the vertex count;
    // the last edge in use closes back to vertex 0.
    assign active  = 32'(n_cnt) > IDX;
    assign is_last = 32'(n_last) == IDX;
    assign ex      = is_last ? v0x : nx;
    assign ey      = is_last ? v0y : ny;

    // Differences for the cross product of this cell's edge.
    assign dx_e = DIFF_W'(ex) - DIFF_W'(vx_reg);
    assign dy_e = DIFF_W'(ey) - DIFF_W'(vy_reg);
    assign dx_p = DIFF_W'(tok_in.px) - DIFF_W'(vx_reg);
    assign dy_p = DIFF_W'(tok_in.py) - DIFF_W'(vy_reg);

    // Finish the previous cell's test: upward crossing with the point left
    // adds one, downward crossing with the point right subtracts one.
    assign hit_up = tok_in.pend_up && (tok_in.prod_l > tok_in.prod_r);
    assign hit_dn = tok_in.pend_dn && (tok_in.prod_l < tok_in.prod_r);

    always_comb
    begin
        wn_next = wn_in;
        if (hit_up)
        begin
            wn_next = wn_in + WN_W'(1);
        end
        else if (hit_dn)
        begin
            wn_next = wn_in - WN_W'(1);
        end
    end

    // Start this cell's test: crossing direction now, products registered.
    always_comb
    begin
        tok_next         = tok_in;
        tok_next.pend_up = active && (vy_reg <= tok_in.py) && (ey > tok_in.py);
        tok_next.pend_dn = active && (vy_reg > tok_in.py) && (ey <= tok_in.py);
        tok_next.prod_l  = dx_e * dy_p;
        tok_next.prod_r  = dx_p * dy_e;
    end

    // Vertex storage, written by a load beat addressed to this cell.
    always_ff @(posedge clk)
    begin
        if (load && (32'(ld_idx) == IDX))
        begin
            vx_reg <= ld_x;
            vy_reg <= ld_y;
        end
    end

    // Token valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    // Token payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tok_reg <= tok_next;
            wn_reg  <= wn_next;
        end
    end

    assign vx      = vx_reg;
    assign vy      = vy_reg;
    assign vld_out = vld_reg;
    assign tok_out = tok_reg;
    assign wn_out  = wn_reg;

endmodule

`default_nettype wire

>>> rtl/winding_number_point_in_polygon_unit.sv
// Top level of the winding-number point-in-polygon unit: cell chain and handshakes.
//
//   channel | signals                      | direction | beat
//   --------+------------------------------+-----------+---------------------------
//   req     | req_valid req_stall req_data | in        | load one vertex or query
//   rsp     | rsp_valid rsp_stall rsp_data | out       | winding number, inside
//   cfg     | cfg_we cfg_wdata             | in        | vertex count write
//
// A load beat writes its vertex into the cell of that index; like any request beat, it is
// taken only while no query is in flight. A query beat enters cell 0 and walks the chain
// of MAX_VERTICES cells, one cell a cycle unless the chain is held; its response is
// registered at the end, and no new request beat is taken until it is captured.
// Reset clears the vertex count and the control flags; vertex contents are kept as-is.
// A stalled response holds the chain when the query reaches its end; req stalls meanwhile.
`default_nettype none

module winding_number_point_in_polygon_unit #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  wnpip_pkg::req_t                     req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output wnpip_pkg::rsp_t                     rsp_data,
    input  logic                                cfg_we,
    input  logic [wnpip_pkg::COUNT_BITS-1:0]    cfg_wdata
);
    import wnpip_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int WN_W  = CNT_W + 1;

    logic [COUNT_BITS-1:0] count_reg;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  rsp_vld_reg;
    logic                  rsp_vld_next;
    rsp_t                  rsp_reg;

    logic [CNT_W-1:0]      n_eff;
    logic [CNT_W-1:0]      n_last;
    logic                  req_acc;
    logic                  load;
    logic                  query;
    logic                  en;
    logic                  capture;

    logic signed [COORD_BITS-1:0] vx_w [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] vy_w [MAX_VERTICES];
    tok_t                         tok_w [MAX_VERTICES + 1];
    logic signed [WN_W-1:0]       wn_w  [MAX_VERTICES + 1];
    logic                         vld_w [MAX_VERTICES + 1];
    logic [MAX_VERTICES-1:0]      cell_vld;

    tok_t                         tail_tok;
    logic signed [WN_W-1:0]       wn_fin;
    int                           wn_sat;

    // Handshake decode.
    assign req_stall = busy_reg;
    assign req_acc   = req_valid && !req_stall;
    assign load      = req_acc && (req_data.kind == KIND_LOAD);
    assign query     = req_acc && (req_data.kind == KIND_QUERY);

    // The chain moves unless a finished query would overwrite a held response.
    assign capture = vld_w[MAX_VERTICES] && (!rsp_vld_reg || !rsp_stall);
    assign en      = !vld_w[MAX_VERTICES] || !rsp_vld_reg || !rsp_stall;

    // Vertex count in use, clamped to the store depth.
    always_comb
    begin
        if (32'(count_reg) > MAX_VERTICES)
        begin
            n_eff = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_eff = CNT_W'(count_reg);
        end
        n_last = n_eff - CNT_W'(1);
    end

    // Token entering cell 0: the query point with nothing pending.
    always_comb
    begin
        tok_w[0]         = '0;
        tok_w[0].px      = req_data.coord_x;
        tok_w[0].py      = req_data.coord_y;
        tok_w[0].pend_up = 1'b0;
        tok_w[0].pend_dn = 1'b0;
    end
    assign wn_w[0]  = '0;
    assign vld_w[0] = query;

    // Chain of cells, each handing the token to its neighbor.
    for (genvar k = 0; k < MAX_VERTICES; k++)
    begin : g_cell
        localparam int NXT = (k + 1) % MAX_VERTICES;

        wnpip_cell #(
            .IDX   (k),
            .CNT_W (CNT_W),
            .WN_W  (WN_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .load    (load),
            .ld_idx  (req_data.vertex_index),
            .ld_x    (req_data.coord_x),
            .ld_y    (req_data.coord_y),
            .nx      (vx_w[NXT]),
            .ny      (vy_w[NXT]),
            .v0x     (vx_w[0]),
            .v0y     (vy_w[0]),
            .n_cnt   (n_eff),
            .n_last  (n_last),
            .vld_in  (vld_w[k]),
            .tok_in  (tok_w[k]),
            .wn_in   (wn_w[k]),
            .vx      (vx_w[k]),
            .vy      (vy_w[k]),
            .vld_out (vld_w[k + 1]),
            .tok_out (tok_w[k + 1]),
            .wn_out  (wn_w[k + 1])
        );

        assign cell_vld[k] = vld_w[k + 1];
    end

    // Finish the last cell's pending test and saturate to the output range.
    assign tail_tok = tok_w[MAX_VERTICES];

    always_comb
    begin
        wn_fin = wn_w[MAX_VERTICES];
        if (tail_tok.pend_up && (tail_tok.prod_l > tail_tok.prod_r))
        begin
            wn_fin = wn_w[MAX_VERTICES] + WN_W'(1);
        end
        else if (tail_tok.pend_dn && (tail_tok.prod_l < tail_tok.prod_r))
        begin
            wn_fin = wn_w[MAX_VERTICES] - WN_W'(1);
        end

        wn_sat = int'(wn_fin);
        if (wn_sat > WN_OUT_MAX)
        begin
            wn_sat = WN_OUT_MAX;
        end
        else if (wn_sat < WN_OUT_MIN)
        begin
            wn_sat = WN_OUT_MIN;
        end
    end

    // Control next state.
    always_comb
    begin
        busy_next = busy_reg;
        if (query)
        begin
            busy_next = 1'b1;
        end
        else if (capture)
        begin
            busy_next = 1'b0;
        end

        rsp_vld_next = rsp_vld_reg;
        if (capture)
        begin
            rsp_vld_next = 1'b1;
        end
        else if (rsp_vld_reg && !rsp_stall)
        begin
            rsp_vld_next = 1'b0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            busy_reg    <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            busy_reg    <= busy_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // Response register.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            rsp_reg.winding_number <= WN_OUT_W'(wn_sat);
            rsp_reg.inside_res     <= (wn_sat != 0);
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp_data  = rsp_reg;

`ifndef SYNTH
    // At most one query token travels the chain.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_vld) <= 1)
        else $error("more than one query token in the cell chain");

    // No token is in the chain while the unit is idle.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (cell_vld == '0))
        else $error("query token present while the unit is idle");

    // A response beat appears only at the end of a query walk.
    a_rsp_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(busy_reg))
        else $error("response raised without a query in flight");

    // An accepted query marks the unit busy.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req_data.kind == KIND_QUERY)) |=> busy_reg)
        else $error("accepted query did not start a walk");
`endif

endmodule

`default_nettype wire

>>> bench/tb_winding_number_point_in_polygon_unit.sv
// Self-checking testbench of the winding-number point-in-polygon unit.
`default_nettype none

module tb_winding_number_point_in_polygon_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import wnpip_pkg::*;

    localparam int MAX_VERTICES = 256;
    localparam int ITEM_TARGET  = 1000;
    localparam int CALM_AFTER   = 850;
    // A query walks the whole cell chain, so allow that much before a count write.
    localparam int DRAIN_CYCLES = MAX_VERTICES + 8;
    localparam int COORD_LO     = -32768;
    localparam int COORD_HI     = 32767;

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_SQUARE_CCW,
        SHAPE_SQUARE_CW,
        SHAPE_TRIANGLE
    } shape_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp_data;
    logic                  cfg_we    = 1'b0;
    logic [COUNT_BITS-1:0] cfg_wdata = '0;

    // Beats waiting to be driven and responses still owed by the unit.
    req_t req_backlog[$];
    rsp_t wn_expected[$];

    // Polygon as the unit sees it at acceptance time, and the vertex count in force.
    logic signed [COORD_BITS-1:0] poly_x[MAX_VERTICES];
    logic signed [COORD_BITS-1:0] poly_y[MAX_VERTICES];
    int                           poly_count = 0;

    // Polygon as planned when beats are queued, used to aim query points.
    int plan_x[MAX_VERTICES];
    int plan_y[MAX_VERTICES];
    int box_xl, box_xh, box_yl, box_yh;

    bit   req_gaps_on   = 1'b0;
    bit   rsp_stalls_on = 1'b0;
    bit   calm          = 1'b0;
    int   gap_left      = 0;
    int   stall_left    = 0;
    rsp_t oldest;

    int items_queued      = 0;
    int loads_taken       = 0;
    int queries_taken     = 0;
    int responses_checked = 0;
    int count_writes      = 0;
    int peak_winding      = 0;
    int mismatch_count    = 0;

    winding_number_point_in_polygon_unit #(
        .MAX_VERTICES (MAX_VERTICES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Winding number of the stored polygon around one point, saturated to the field.
    function automatic rsp_t expected_response(logic signed [COORD_BITS-1:0] qx,
                                               logic signed [COORD_BITS-1:0] qy);
        rsp_t   r;
        int     edges;
        int     j;
        int     wn;
        longint px, py, sx, sy, ex, ey, turn;
        px = qx;
        py = qy;
        edges = (poly_count > MAX_VERTICES) ? MAX_VERTICES : poly_count;
        wn = 0;
        for (int i = 0; i < edges; i++)
        begin
            j = (i + 1 == edges) ? 0 : i + 1;
            sx = poly_x[i];
            sy = poly_y[i];
            ex = poly_x[j];
            ey = poly_y[j];
            // Positive when the point lies strictly left of the edge.
            turn = (ex - sx) * (py - sy) - (px - sx) * (ey - sy);
            if (sy <= py)
            begin
                if (ey > py && turn > 0)
                    wn++;
            end
            else
            begin
                if (ey <= py && turn < 0)
                    wn--;
            end
        end
        if (wn > WN_OUT_MAX)
            wn = WN_OUT_MAX;
        if (wn < WN_OUT_MIN)
            wn = WN_OUT_MIN;
        r.winding_number = WN_OUT_W'(wn);
        r.inside_res     = (wn != 0);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Request driver: takes beats from the backlog, with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
            gap_left  <= 0;
        end
        else
        begin
            // Update the shadow store or predict the response for the beat taken here.
            if (req_valid && !req_stall)
            begin
                if (req_data.kind == KIND_LOAD)
                begin
                    poly_x[req_data.vertex_index] = req_data.coord_x;
                    poly_y[req_data.vertex_index] = req_data.coord_y;
                    loads_taken++;
                end
                else
                begin
                    wn_expected.push_back(expected_response(req_data.coord_x,
                                                            req_data.coord_y));
                    if (wn_expected[$].winding_number > peak_winding)
                        peak_winding = wn_expected[$].winding_number;
                    if (-wn_expected[$].winding_number > peak_winding)
                        peak_winding = -wn_expected[$].winding_number;
                    queries_taken++;
                end
            end
            // A stalled beat holds; otherwise idle or present the next one.
            if (!req_valid || !req_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left  <= gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (req_gaps_on && $urandom_range(0, 7) == 0)
                begin
                    gap_left  <= $urandom_range(0, 10);
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() != 0)
                begin
                    req_data  <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Response monitor: checks each taken beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (wn_expected.size() == 0)
                    report_mismatch("response beat with nothing outstanding");
                else
                begin
                    oldest = wn_expected.pop_front();
                    responses_checked++;
                    if (rsp_data.winding_number !== oldest.winding_number)
                        report_mismatch($sformatf("winding_number got %0d expected %0d",
                            rsp_data.winding_number, oldest.winding_number));
                    if (rsp_data.inside_res !== oldest.inside_res)
                        report_mismatch($sformatf("inside_res got %b expected %b",
                            rsp_data.inside_res, oldest.inside_res));
                end
            end
            // Stall bursts of random length.
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                rsp_stall  <= 1'b1;
            end
            else if (rsp_stalls_on && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 10);
                rsp_stall  <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    function automatic int rand_span(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic queue_vertex(int idx, int x, int y);
        req_t beat;
        beat.kind         = KIND_LOAD;
        beat.vertex_index = INDEX_BITS'(idx);
        beat.coord_x      = COORD_BITS'(x);
        beat.coord_y      = COORD_BITS'(y);
        plan_x[idx] = x;
        plan_y[idx] = y;
        req_backlog.push_back(beat);
        items_queued++;
    endtask

    task automatic queue_point(int x, int y);
        req_t beat;
        beat.kind         = KIND_QUERY;
        beat.vertex_index = INDEX_BITS'($urandom);
        beat.coord_x      = COORD_BITS'(x);
        beat.coord_y      = COORD_BITS'(y);
        req_backlog.push_back(beat);
        items_queued++;
    endtask

    // Wait until every beat is taken and answered, then let the chain empty out.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || req_valid || wn_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_vertex_count(int count);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= COUNT_BITS'(count);
        @(posedge clk);
        cfg_we    <= 1'b0;
        poly_count = count;
        count_writes++;
        @(negedge clk);
    endtask

    // Pick a bounding box: the full coordinate range, or a tight or wide box.
    task automatic pick_box();
        int cx, cy, hx, hy;
        if ($urandom_range(0, 3) == 0)
        begin
            box_xl = COORD_LO;
            box_xh = COORD_HI;
            box_yl = COORD_LO;
            box_yh = COORD_HI;
        end
        else
        begin
            hx = $urandom_range(0, 1) ? rand_span(1, 40) : rand_span(41, 16000);
            hy = $urandom_range(0, 1) ? rand_span(1, 40) : rand_span(41, 16000);
            cx = rand_span(-16000, 16000);
            cy = rand_span(-16000, 16000);
            box_xl = cx - hx;
            box_xh = cx + hx;
            box_yl = cy - hy;
            box_yh = cy + hy;
        end
    endtask

    // Load vertices 0 .. n-1; looped squares and triangles wind several times.
    task automatic queue_polygon(int n, shape_t shape);
        int corner;
        for (int i = 0; i < n; i++)
        begin
            case (shape)
                SHAPE_SQUARE_CCW, SHAPE_SQUARE_CW:
                begin
                    corner = (shape == SHAPE_SQUARE_CCW) ? i % 4 : 3 - i % 4;
                    queue_vertex(i, (corner == 0 || corner == 3) ? box_xl : box_xh,
                                 (corner < 2) ? box_yl : box_yh);
                end
                SHAPE_TRIANGLE:
                begin
                    corner = i % 3;
                    if (corner == 2)
                        queue_vertex(i, (box_xl + box_xh) / 2, box_yh);
                    else
                        queue_vertex(i, corner == 0 ? box_xl : box_xh, box_yl);
                end
                default:
                    queue_vertex(i, rand_span(box_xl, box_xh), rand_span(box_yl, box_yh));
            endcase
        end
    endtask

    // Query points at vertices, vertex rows and columns, edge midpoints, the box or anywhere.
    task automatic queue_query(int n);
        int pick, i, j;
        pick = $urandom_range(0, 9);
        i = (n > 0) ? $urandom_range(0, n - 1) : 0;
        j = (i + 1 == n) ? 0 : i + 1;
        if (pick >= 8)
            queue_point(rand_span(COORD_LO, COORD_HI), rand_span(COORD_LO, COORD_HI));
        else if (n == 0 || pick < 4)
            queue_point(rand_span(box_xl, box_xh), rand_span(box_yl, box_yh));
        else if (pick == 4)
            queue_point(plan_x[i], plan_y[i]);
        else if (pick == 5)
            queue_point(rand_span(box_xl, box_xh), plan_y[i]);
        else if (pick == 6)
            queue_point((plan_x[i] + plan_x[j]) / 2, (plan_y[i] + plan_y[j]) / 2);
        else
            queue_point(plan_x[i], rand_span(box_yl, box_yh));
    endtask

    task automatic run_phase(int count, shape_t shape, int extra_items);
        int n;
        set_vertex_count(count);
        n = (count > MAX_VERTICES) ? MAX_VERTICES : count;
        calm = (items_queued >= CALM_AFTER);
        req_gaps_on   = !calm && $urandom_range(0, 3) != 0;
        rsp_stalls_on = !calm && $urandom_range(0, 3) != 0;
        pick_box();
        queue_polygon(n, shape);
        // Mostly queries on the fresh polygon, with stray loads mixed in.
        repeat (extra_items)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_vertex($urandom_range(0, MAX_VERTICES - 1),
                             rand_span(COORD_LO, COORD_HI), rand_span(COORD_LO, COORD_HI));
            else
                queue_query(n);
        end
    endtask

    // Main sequence: reset, directed polygons, then random phases.
    initial
    begin
        int     phase_no;
        int     count;
        shape_t shape;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;

        // Empty polygon: no edges, winding zero.
        set_vertex_count(0);
        queue_point(COORD_LO, COORD_HI);
        queue_point(COORD_HI, COORD_LO);

        // One vertex: a single degenerate edge.
        set_vertex_count(1);
        queue_vertex(0, COORD_LO, COORD_LO);
        queue_point(0, 0);
        queue_point(COORD_LO, COORD_LO);

        // Full-range triangle: inside, on a vertex, on an edge, outside.
        set_vertex_count(3);
        queue_vertex(1, COORD_HI, COORD_LO);
        queue_vertex(2, 0, COORD_HI);
        queue_point(0, 0);
        queue_point(COORD_LO, COORD_LO);
        queue_point(0, COORD_LO);
        queue_point(16383, 0);
        queue_point(COORD_HI, COORD_HI);
        queue_point(0, COORD_HI);

        // Clockwise square: negative winding, points on its edges.
        set_vertex_count(4);
        queue_vertex(0, -10, -10);
        queue_vertex(1, -10, 10);
        queue_vertex(2, 10, 10);
        queue_vertex(3, 10, -10);
        queue_point(0, 0);
        queue_point(-10, 0);
        queue_point(10, 0);
        queue_point(0, 10);

        // Two vertices: an edge out and straight back.
        set_vertex_count(2);
        queue_point(-5, 0);

        phase_no = 0;
        while (items_queued < ITEM_TARGET)
        begin
            shape = shape_t'($urandom_range(0, 3));
            if (phase_no == 2)
            begin
                count = MAX_VERTICES;
                shape = SHAPE_SQUARE_CCW;
            end
            else if (phase_no == 5)
            begin
                count = (1 << COUNT_BITS) - 1;
                shape = SHAPE_TRIANGLE;
            end
            else if (phase_no == 8)
                count = $urandom_range(MAX_VERTICES + 1, (1 << COUNT_BITS) - 2);
            else
            begin
                case ($urandom_range(0, 9))
                    0:       count = $urandom_range(0, 2);
                    1, 2:    count = $urandom_range(13, 64);
                    default: count = $urandom_range(3, 12);
                endcase
            end
            run_phase(count, shape, $urandom_range(8, 24));
            phase_no++;
        end

        wait_idle();
        $display("Ran %0d vertex loads and %0d point queries across %0d vertex-count settings.",
                 loads_taken, queries_taken, count_writes);
        $display("Checked %0d responses; largest winding magnitude seen was %0d.",
                 responses_checked, peak_winding);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #10ms;
        $display("Timed out with %0d responses outstanding.", wn_expected.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/wnpip_pkg.sv
rtl/wnpip_cell.sv
rtl/winding_number_point_in_polygon_unit.sv
bench/tb_winding_number_point_in_polygon_unit.sv
